[hw/rtl/qse_pkg.sv]
// Shared constants and types for the quicksort engine.
package qse_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(MAX_ITEMS);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int STACK_BITS = 2 * IDX_BITS;

   typedef struct packed {
      logic [IDX_BITS-1:0] hi;
      logic [IDX_BITS-1:0] lo;
   } range_type;

endpackage

[hw/rtl/quicksort_engine_top.sv]
// Top level of the quicksort engine: load, sort and emit sequencer.
//
//   Channel  Ports                           Beat taken when
//   -------  ------------------------------  ------------------------------
//   request  start, busy, req_value,         start high while busy is low
//            req_last
//   response rsp_strobe, rsp_sorted_value,   every cycle rsp_strobe is high
//            rsp_final_res
//
// The beat that carries last, or the one that fills the store to MAX_ITEMS
// entries, starts a sort. The sort works with one comparator and one port
// pair on the element memory: each element of a range is compared in
// ST_CMP and, when it is below the pivot, swapped through ST_SW1 and ST_SW2,
// and each range adds the pop, pivot fetch, final swap and push states. A
// list of N items then streams out as N beats, one beat per cycle.
// Synchronous reset empties the list and returns the sequencer to idle; the
// memories need no clearing since only entries written for the current list
// are ever read. The receiver cannot stall, so busy stays high from the last
// load beat until the final result beat has been issued.
module quicksort_engine_top
   import qse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [31:0] rsp_sorted_value,
   output logic        rsp_final_res
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_POP   = 4'd1;
   localparam logic [3:0] ST_RANGE = 4'd2;
   localparam logic [3:0] ST_PIVOT = 4'd3;
   localparam logic [3:0] ST_CMP   = 4'd4;
   localparam logic [3:0] ST_SW1   = 4'd5;
   localparam logic [3:0] ST_SW2   = 4'd6;
   localparam logic [3:0] ST_FIN1  = 4'd7;
   localparam logic [3:0] ST_FIN2  = 4'd8;
   localparam logic [3:0] ST_PUSHA = 4'd9;
   localparam logic [3:0] ST_PUSHB = 4'd10;
   localparam logic [3:0] ST_EMIT  = 4'd11;

   logic [3:0]            state_ff,  state_in;
   logic [CNT_BITS-1:0]   count_ff,  count_in;
   logic [CNT_BITS-1:0]   n_ff,      n_in;
   logic [CNT_BITS-1:0]   sp_ff,     sp_in;
   logic [IDX_BITS-1:0]   lo_ff,     lo_in;
   logic [IDX_BITS-1:0]   hi_ff,     hi_in;
   logic [IDX_BITS-1:0]   i_ff,      i_in;
   logic [IDX_BITS-1:0]   split_ff,  split_in;
   logic [IDX_BITS-1:0]   k_ff,      k_in;
   logic [VALUE_BITS-1:0] pivot_ff,  pivot_in;
   logic [VALUE_BITS-1:0] hold_ff,   hold_in;
   logic                  emit_v_ff, emit_v_in;
   logic                  emit_l_ff, emit_l_in;

   // Element memory ports.
   logic                  st_we;
   logic [IDX_BITS-1:0]   st_wa;
   logic [VALUE_BITS-1:0] st_wd;
   logic [IDX_BITS-1:0]   st_ra;
   logic [VALUE_BITS-1:0] st_rd;

   // Range stack ports.
   logic                  sk_we;
   logic [IDX_BITS-1:0]   sk_wa;
   range_type             sk_wd;
   logic [IDX_BITS-1:0]   sk_ra;
   logic [STACK_BITS-1:0] sk_rd;
   range_type             sk_range;

   logic [CNT_BITS-1:0]   count_next;
   logic [CNT_BITS-1:0]   sp_next;
   logic                  list_end;

   qse_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wa),
      .wr_data (st_wd),
      .rd_addr (st_ra),
      .rd_data (st_rd)
   );

   qse_ram #(.WIDTH(STACK_BITS), .DEPTH(MAX_ITEMS)) u_stack (
      .clock   (clock),
      .wr_en   (sk_we),
      .wr_addr (sk_wa),
      .wr_data (sk_wd),
      .rd_addr (sk_ra),
      .rd_data (sk_rd)
   );

   assign sk_range   = range_type'(sk_rd);
   assign count_next = count_ff + CNT_BITS'(1);
   assign list_end   = req_last || (count_next == CNT_BITS'(MAX_ITEMS));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      sp_in     = sp_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      split_in  = split_ff;
      k_in      = k_ff;
      pivot_in  = pivot_ff;
      hold_in   = hold_ff;
      emit_v_in = 1'b0;
      emit_l_in = 1'b0;
      sp_next   = sp_ff;

      st_we = 1'b0;
      st_wa = i_ff;
      st_wd = hold_ff;
      st_ra = i_ff;
      sk_we = 1'b0;
      sk_wa = sp_ff[IDX_BITS-1:0];
      sk_wd = '{hi: hi_ff, lo: lo_ff};
      sk_ra = sp_ff[IDX_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               st_we = 1'b1;
               st_wa = count_ff[IDX_BITS-1:0];
               st_wd = VALUE_BITS'(req_value);
               if (list_end) begin
                  n_in     = count_next;
                  count_in = '0;
                  k_in     = '0;
                  if (count_next > CNT_BITS'(1)) begin
                     // Seed the stack with the whole list.
                     sk_we    = 1'b1;
                     sk_wa    = '0;
                     sk_wd    = '{hi: count_ff[IDX_BITS-1:0], lo: '0};
                     sp_in    = CNT_BITS'(1);
                     state_in = ST_POP;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  count_in = count_next;
               end
            end
         end
         ST_POP: begin
            sp_next  = sp_ff - CNT_BITS'(1);
            sk_ra    = sp_next[IDX_BITS-1:0];
            sp_in    = sp_next;
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            lo_in    = sk_range.lo;
            hi_in    = sk_range.hi;
            st_ra    = sk_range.lo;
            state_in = ST_PIVOT;
         end
         ST_PIVOT: begin
            pivot_in = st_rd;
            split_in = lo_ff;
            i_in     = lo_ff + IDX_BITS'(1);
            st_ra    = lo_ff + IDX_BITS'(1);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (st_rd < pivot_ff) begin
               split_in = split_ff + IDX_BITS'(1);
               hold_in  = st_rd;
               st_ra    = split_ff + IDX_BITS'(1);
               state_in = ST_SW1;
            end else if (i_ff == hi_ff) begin
               st_ra    = split_ff;
               state_in = ST_FIN1;
            end else begin
               i_in  = i_ff + IDX_BITS'(1);
               st_ra = i_ff + IDX_BITS'(1);
            end
         end
         ST_SW1: begin
            // The smaller element moves down to the split point.
            st_we    = 1'b1;
            st_wa    = split_ff;
            st_wd    = hold_ff;
            hold_in  = st_rd;
            state_in = ST_SW2;
         end
         ST_SW2: begin
            st_we = 1'b1;
            st_wa = i_ff;
            st_wd = hold_ff;
            if (i_ff == hi_ff) begin
               st_ra    = split_ff;
               state_in = ST_FIN1;
            end else begin
               i_in     = i_ff + IDX_BITS'(1);
               st_ra    = i_ff + IDX_BITS'(1);
               state_in = ST_CMP;
            end
         end
         ST_FIN1: begin
            st_we    = 1'b1;
            st_wa    = lo_ff;
            st_wd    = st_rd;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            st_we    = 1'b1;
            st_wa    = split_ff;
            st_wd    = pivot_ff;
            state_in = ST_PUSHA;
         end
         ST_PUSHA: begin
            // Lower part holds at least two elements.
            if ((CNT_BITS'(split_ff) > CNT_BITS'(lo_ff) + CNT_BITS'(1)) &&
                (sp_ff < CNT_BITS'(MAX_ITEMS))) begin
               sk_we = 1'b1;
               sk_wd = '{hi: split_ff - IDX_BITS'(1), lo: lo_ff};
               sp_in = sp_ff + CNT_BITS'(1);
            end
            state_in = ST_PUSHB;
         end
         ST_PUSHB: begin
            if ((CNT_BITS'(split_ff) + CNT_BITS'(1) < CNT_BITS'(hi_ff)) &&
                (sp_ff < CNT_BITS'(MAX_ITEMS))) begin
               sk_we   = 1'b1;
               sk_wd   = '{hi: hi_ff, lo: split_ff + IDX_BITS'(1)};
               sp_next = sp_ff + CNT_BITS'(1);
            end
            sp_in = sp_next;
            if (sp_next == '0) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_EMIT: begin
            st_ra     = k_ff;
            emit_v_in = 1'b1;
            emit_l_in = (CNT_BITS'(k_ff) + CNT_BITS'(1) == n_ff);
            if (CNT_BITS'(k_ff) + CNT_BITS'(1) == n_ff) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + IDX_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         sp_ff     <= '0;
         emit_v_ff <= 1'b0;
         emit_l_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sp_ff     <= sp_in;
         emit_v_ff <= emit_v_in;
         emit_l_ff <= emit_l_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      split_ff <= split_in;
      k_ff     <= k_in;
      pivot_ff <= pivot_in;
      hold_ff  <= hold_in;
   end

   // Results come straight from the registered read of the element memory.
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = emit_v_ff;
   assign rsp_sorted_value = 32'(st_rd);
   assign rsp_final_res    = emit_l_ff;

endmodule

[hw/rtl/qse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module qse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the contents from before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
